[design/bbd_pkg.sv]
// ----------------------------------------------------------------------------
// Byte budget deque package
// Opcodes, status codes, fixed field widths and the control structs that
// pass between the deque modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bbd_pkg;

   localparam int HANDLE_W = 32;
   localparam int LIMIT_W  = 22;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 22'd16384;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_CLEAR      = 3'd6
   } bbd_opcode_type;

   localparam logic ST_OK    = 1'b0;
   localparam logic ST_EMPTY = 1'b1;

   typedef struct packed {
      logic push;
      logic pop;
      logic peek;
      logic clear;
      logic at_back;
   } bbd_op_type;

   typedef struct packed {
      logic status;
      logic dropped;
      logic show_out;
   } bbd_flag_type;

   function automatic bbd_op_type bbd_decode(input logic [2:0] code);
      bbd_op_type op;
      op = '0;
      unique case (code)
         OP_PUSH_FRONT: op.push = 1'b1;
         OP_PUSH_BACK: begin
            op.push    = 1'b1;
            op.at_back = 1'b1;
         end
         OP_POP_FRONT: op.pop = 1'b1;
         OP_POP_BACK: begin
            op.pop     = 1'b1;
            op.at_back = 1'b1;
         end
         OP_PEEK_FRONT: op.peek = 1'b1;
         OP_PEEK_BACK: begin
            op.peek    = 1'b1;
            op.at_back = 1'b1;
         end
         OP_CLEAR: op.clear = 1'b1;
         default: op = '0;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

[design/bbd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module bbd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/bbd_state.sv]
// ----------------------------------------------------------------------------
// Byte budget deque state
// Holds the head index, entry count, byte total and byte limit. Decides
// drops, computes the next state, the store write slot and the read slot
// for the incoming item.
// ----------------------------------------------------------------------------
`default_nettype none

module bbd_state import bbd_pkg::*; #(
   parameter int DEPTH    = 64,
   parameter int LEN_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_en,
   input  wire logic [LIMIT_W-1:0]           csr_write_data,
   input  wire logic                         fire,
   input  wire bbd_op_type                   cur_op,
   input  wire logic [LEN_BITS-1:0]          cur_len,
   input  wire logic [LEN_BITS-1:0]          cur_rd_len,
   input  wire logic                         nxt_read_back,
   output logic      [$clog2(DEPTH)-1:0]     rd_addr,
   output logic                              wr_en,
   output logic      [$clog2(DEPTH)-1:0]     wr_addr,
   output bbd_flag_type                      flags,
   output logic      [$clog2(DEPTH+1)-1:0]   op_count,
   output logic      [LIMIT_W-1:0]           op_total
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int BW = (LEN_BITS + CW > LIMIT_W) ? LEN_BITS + CW : LIMIT_W;
   localparam int XW = BW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

   logic [AW-1:0]      head_ff, head_in, op_head;
   logic [CW-1:0]      count_ff, count_in;
   logic [BW-1:0]      bytes_ff, bytes_in, op_bytes, bytes_less;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [XW-1:0]      trial_sum;
   logic [LEN_BITS-1:0] sub_len;
   logic               empty, drop, took;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] i);
      return (i == LAST_C) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] i);
      return (i == '0) ? LAST_C : i - AW'(1);
   endfunction

   function automatic logic [AW-1:0] back_slot(input logic [AW-1:0] h,
                                               input logic [CW-1:0] c);
      return (c == '0) ? h : wrap_add(h, c - CW'(1));
   endfunction

   always_comb begin
      empty     = (count_ff == '0);
      trial_sum = XW'(bytes_ff) + XW'(cur_len);
      drop      = cur_op.push && !empty &&
                  ((trial_sum > XW'(limit_ff)) || (count_ff == DEPTH_C));
      took      = cur_op.pop && !empty;
      sub_len   = (drop || took) ? cur_rd_len : '0;
      bytes_less = (bytes_ff >= BW'(sub_len)) ? bytes_ff - BW'(sub_len) : '0;

      op_head  = head_ff;
      op_count = count_ff;
      op_bytes = bytes_ff;
      wr_addr  = head_ff;
      if (cur_op.push) begin
         op_count = drop ? count_ff : count_ff + CW'(1);
         op_bytes = bytes_less + BW'(cur_len);
         if (cur_op.at_back) begin
            op_head = drop ? slot_inc(head_ff) : head_ff;
            wr_addr = wrap_add(head_ff, count_ff);
         end else begin
            op_head = slot_dec(head_ff);
            wr_addr = slot_dec(head_ff);
         end
      end else if (took) begin
         op_count = count_ff - CW'(1);
         op_bytes = bytes_less;
         op_head  = cur_op.at_back ? head_ff : slot_inc(head_ff);
      end else if (cur_op.clear) begin
         op_head  = '0;
         op_count = '0;
         op_bytes = '0;
      end

      wr_en          = fire && cur_op.push;
      flags.status   = ((cur_op.pop || cur_op.peek) && empty) ? ST_EMPTY : ST_OK;
      flags.dropped  = drop;
      flags.show_out = (cur_op.pop || cur_op.peek) && !empty;
      op_total       = op_bytes[LIMIT_W-1:0];

      head_in  = fire ? op_head : head_ff;
      count_in = fire ? op_count : count_ff;
      bytes_in = fire ? op_bytes : bytes_ff;
      limit_in = csr_write_en ? csr_write_data : limit_ff;
      rd_addr  = nxt_read_back ? back_slot(head_in, count_in) : head_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         bytes_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         bytes_ff <= bytes_in;
         limit_ff <= limit_in;
      end
   end

endmodule

`default_nettype wire

[design/byte_budget_deque.sv]
// ----------------------------------------------------------------------------
// Byte budget deque
// Double-ended queue of message descriptors with a running byte total. A
// push that would exceed the byte limit, or that finds the store full,
// first evicts one entry from the opposite end and reports it.
//
//   Port group  Direction  Handshake            Contents
//   req_*       in         req_valid/req_stall  opcode, handle, length
//   rsp_*       out        rsp_valid/rsp_stall  status, entry, eviction, totals
//   csr_*       in         csr_write_en         byte limit
//
// One item per cycle is sustained while rsp_stall is low. An accepted item
// reads the descriptor store and is registered into the execute stage; when
// it executes, its result is registered and presented on the rsp_* ports.
// The single read port of the store and the next-state path of the head and
// count set this rate. Reset empties the queue and loads a byte limit of
// 16384; no store clear is needed. While rsp_stall holds a result, the
// execute stage holds too and req_stall rises if it holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_budget_deque import bbd_pkg::*; #(
   parameter int DEPTH    = 64,
   parameter int LEN_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic [LIMIT_W-1:0]         csr_write_data,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [2:0]                 req_opcode,
   input  wire logic [HANDLE_W-1:0]        req_msg_handle,
   input  wire logic [LEN_BITS-1:0]        req_msg_len,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_status,
   output logic      [HANDLE_W-1:0]        rsp_out_handle,
   output logic      [LEN_BITS-1:0]        rsp_out_len,
   output logic                            rsp_dropped,
   output logic      [HANDLE_W-1:0]        rsp_dropped_handle,
   output logic      [LEN_BITS-1:0]        rsp_dropped_len,
   output logic      [$clog2(DEPTH+1)-1:0] rsp_entry_count,
   output logic      [LIMIT_W-1:0]         rsp_byte_total
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = HANDLE_W + LEN_BITS;

   logic                e_valid_ff, e_valid_in;
   bbd_op_type          e_op_ff;
   logic [HANDLE_W-1:0] e_handle_ff;
   logic [LEN_BITS-1:0] e_len_ff;
   logic                byp_ff;
   logic [WW-1:0]       byp_data_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_dropped_ff;
   logic [HANDLE_W-1:0] rsp_out_handle_ff, rsp_dropped_handle_ff;
   logic [LEN_BITS-1:0] rsp_out_len_ff, rsp_dropped_len_ff;
   logic [CW-1:0]       rsp_entry_count_ff;
   logic [LIMIT_W-1:0]  rsp_byte_total_ff;

   bbd_op_type          req_op;
   bbd_flag_type        flags;
   logic                fire, accept, nxt_read_back, wr_en, byp_hit;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic [WW-1:0]       ram_rd_data, rd_word, wr_data;
   logic [HANDLE_W-1:0] rd_handle;
   logic [LEN_BITS-1:0] rd_len;
   logic [CW-1:0]       op_count;
   logic [LIMIT_W-1:0]  op_total;

   always_comb begin
      req_op        = bbd_decode(req_opcode);
      nxt_read_back = req_op.push ? !req_op.at_back : req_op.at_back;
      fire          = e_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall     = e_valid_ff && !fire;
      accept        = req_valid && !req_stall;
      e_valid_in    = accept || (e_valid_ff && !fire);
      rsp_valid_in  = fire || (rsp_valid_ff && rsp_stall);
      wr_data       = {e_handle_ff, e_len_ff};
      byp_hit       = wr_en && (wr_addr == rd_addr);
      rd_word       = byp_ff ? byp_data_ff : ram_rd_data;
      rd_handle     = rd_word[WW-1:LEN_BITS];
      rd_len        = rd_word[LEN_BITS-1:0];
   end

   bbd_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   bbd_state #(
      .DEPTH    (DEPTH),
      .LEN_BITS (LEN_BITS)
   ) u_state (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fire           (fire),
      .cur_op         (e_op_ff),
      .cur_len        (e_len_ff),
      .cur_rd_len     (rd_len),
      .nxt_read_back  (nxt_read_back),
      .rd_addr        (rd_addr),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .flags          (flags),
      .op_count       (op_count),
      .op_total       (op_total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         e_valid_ff   <= e_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A transfer that reads the slot being written in the same cycle takes
   // the written word instead of the stale store contents.
   always_ff @(posedge clock) begin
      if (accept) begin
         e_op_ff     <= req_op;
         e_handle_ff <= req_msg_handle;
         e_len_ff    <= req_msg_len;
         byp_ff      <= byp_hit;
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff         <= flags.status;
         rsp_out_handle_ff     <= flags.show_out ? rd_handle : '0;
         rsp_out_len_ff        <= flags.show_out ? rd_len : '0;
         rsp_dropped_ff        <= flags.dropped;
         rsp_dropped_handle_ff <= flags.dropped ? rd_handle : '0;
         rsp_dropped_len_ff    <= flags.dropped ? rd_len : '0;
         rsp_entry_count_ff    <= op_count;
         rsp_byte_total_ff     <= op_total;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_handle     = rsp_out_handle_ff;
   assign rsp_out_len        = rsp_out_len_ff;
   assign rsp_dropped        = rsp_dropped_ff;
   assign rsp_dropped_handle = rsp_dropped_handle_ff;
   assign rsp_dropped_len    = rsp_dropped_len_ff;
   assign rsp_entry_count    = rsp_entry_count_ff;
   assign rsp_byte_total     = rsp_byte_total_ff;

   a_stall_needs_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> e_valid_ff)
      else $error("request stalled with an empty execute stage");

   a_empty_has_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_entry_count_ff == '0)) |-> (rsp_byte_total_ff == '0))
      else $error("empty queue reports a nonzero byte total");

   a_drop_leaves_entries: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dropped_ff) |-> (rsp_entry_count_ff != '0))
      else $error("eviction reported with no entry left");

   a_empty_status_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_EMPTY)) |-> (rsp_entry_count_ff == '0))
      else $error("empty status reported on a nonempty queue");

endmodule

`default_nettype wire

[test/bbd_deque_checker.sv]
// ----------------------------------------------------------------------------
// Byte budget deque checker
// Watches the request, result and register ports of the deque. It keeps its
// own copy of the queue contents, head, count, byte total and byte limit. For
// every request transfer it predicts the one result, and it compares each
// result transfer field by field with the oldest prediction. The number of
// mismatches and the number of results still owed are reported to the top.
// ----------------------------------------------------------------------------
module bbd_deque_checker import bbd_pkg::*; #(
   parameter int DEPTH    = 64,
   parameter int LEN_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [LIMIT_W-1:0]         csr_write_data,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [2:0]                 req_opcode,
   input  logic [HANDLE_W-1:0]        req_msg_handle,
   input  logic [LEN_BITS-1:0]        req_msg_len,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_status,
   input  logic [HANDLE_W-1:0]        rsp_out_handle,
   input  logic [LEN_BITS-1:0]        rsp_out_len,
   input  logic                       rsp_dropped,
   input  logic [HANDLE_W-1:0]        rsp_dropped_handle,
   input  logic [LEN_BITS-1:0]        rsp_dropped_len,
   input  logic [$clog2(DEPTH+1)-1:0] rsp_entry_count,
   input  logic [LIMIT_W-1:0]         rsp_byte_total,
   output int                         error_count,
   output int                         pending_count
);

   localparam int CNT_W = $clog2(DEPTH+1);

   typedef struct packed {
      logic                status;
      logic [HANDLE_W-1:0] out_handle;
      logic [LEN_BITS-1:0] out_len;
      logic                dropped;
      logic [HANDLE_W-1:0] dropped_handle;
      logic [LEN_BITS-1:0] dropped_len;
      logic [CNT_W-1:0]    entry_count;
      logic [LIMIT_W-1:0]  byte_total;
   } deque_reply_type;

   logic [HANDLE_W-1:0] handle_mem [DEPTH];
   logic [LEN_BITS-1:0] len_mem [DEPTH];
   int                  head_ptr = 0;
   int                  held_cnt = 0;
   int                  held_sum = 0;
   int                  byte_limit = LIMIT_RESET;
   int                  mismatches = 0;
   deque_reply_type     replies_due [$];

   function automatic deque_reply_type apply_deque_op(input logic [2:0] op,
                                                     input logic [HANDLE_W-1:0] hnd,
                                                     input logic [LEN_BITS-1:0] len);
      deque_reply_type r;
      int              slot;
      int              tail;
      logic            at_back;
      r       = '0;
      at_back = (op == OP_PUSH_BACK) || (op == OP_POP_BACK) || (op == OP_PEEK_BACK);
      tail    = (head_ptr + held_cnt + DEPTH - 1) % DEPTH;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (held_cnt > 0 && (held_sum + len > byte_limit || held_cnt >= DEPTH)) begin
               slot             = at_back ? head_ptr : tail;
               r.dropped        = 1'b1;
               r.dropped_handle = handle_mem[slot];
               r.dropped_len    = len_mem[slot];
               if (at_back) begin
                  head_ptr = (head_ptr + 1) % DEPTH;
               end
               held_cnt = held_cnt - 1;
               held_sum = held_sum - len_mem[slot];
            end
            if (at_back) begin
               slot = (head_ptr + held_cnt) % DEPTH;
            end else begin
               head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
               slot     = head_ptr;
            end
            handle_mem[slot] = hnd;
            len_mem[slot]    = len;
            held_cnt         = held_cnt + 1;
            held_sum         = held_sum + len;
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (held_cnt == 0) begin
               r.status = ST_EMPTY;
            end else begin
               slot         = at_back ? tail : head_ptr;
               r.out_handle = handle_mem[slot];
               r.out_len    = len_mem[slot];
               if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
                  if (!at_back) begin
                     head_ptr = (head_ptr + 1) % DEPTH;
                  end
                  held_cnt = held_cnt - 1;
                  held_sum = held_sum - len_mem[slot];
               end
            end
         end
         OP_CLEAR: begin
            head_ptr = 0;
            held_cnt = 0;
            held_sum = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = held_cnt[CNT_W-1:0];
      r.byte_total  = held_sum[LIMIT_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      deque_reply_type got;
      deque_reply_type want;
      if (reset) begin
         head_ptr   = 0;
         held_cnt   = 0;
         held_sum   = 0;
         byte_limit = LIMIT_RESET;
         replies_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_out_handle, rsp_out_len, rsp_dropped, rsp_dropped_handle,
                   rsp_dropped_len, rsp_entry_count, rsp_byte_total};
            if (replies_due.size() == 0) begin
               $display("%0t: result transfer with no request outstanding, actual 0x%0h",
                        $time, got);
               mismatches++;
            end else begin
               want = replies_due[0];
               replies_due.delete(0);
               check_field("status", want.status, got.status);
               check_field("out_handle", want.out_handle, got.out_handle);
               check_field("out_len", want.out_len, got.out_len);
               check_field("dropped", want.dropped, got.dropped);
               check_field("dropped_handle", want.dropped_handle, got.dropped_handle);
               check_field("dropped_len", want.dropped_len, got.dropped_len);
               check_field("entry_count", want.entry_count, got.entry_count);
               check_field("byte_total", want.byte_total, got.byte_total);
            end
         end
         if (csr_write_en) begin
            byte_limit = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            replies_due.insert(replies_due.size(),
                               apply_deque_op(req_opcode, req_msg_handle, req_msg_len));
         end
      end
      error_count   <= mismatches;
      pending_count <= replies_due.size();
   end

endmodule

[test/tb_byte_budget_deque.sv]
// ----------------------------------------------------------------------------
// Byte budget deque testbench
// Drives opcodes, handles and lengths into the deque under several byte
// limits, from zero to the largest, with random idle bursts on the request
// side and random stall bursts on the result side. A directed opening covers
// empty pops and peeks, pushes on an empty queue, evictions and clear; random
// phases then fill the store, overrun the budget and mix every operation.
// The checker beside the block predicts and compares every transfer.
// ----------------------------------------------------------------------------
module tb_byte_budget_deque;
   import bbd_pkg::*;

   localparam int DEPTH       = 64;
   localparam int LEN_BITS    = 16;
   localparam int CNT_W       = $clog2(DEPTH+1);
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [2:0]         OP_UNUSED = 3'd7;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = 22'd4194240;

   localparam int LEN_TINY  = 0;
   localparam int LEN_FULL  = 1;
   localparam int LEN_MIXED = 2;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [LIMIT_W-1:0]   csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic [2:0]           req_opcode = '0;
   logic [HANDLE_W-1:0]  req_msg_handle = '0;
   logic [LEN_BITS-1:0]  req_msg_len = '0;
   logic                 rsp_stall = 1'b0;

   logic                 req_stall;
   logic                 rsp_valid;
   logic                 rsp_status;
   logic [HANDLE_W-1:0]  rsp_out_handle;
   logic [LEN_BITS-1:0]  rsp_out_len;
   logic                 rsp_dropped;
   logic [HANDLE_W-1:0]  rsp_dropped_handle;
   logic [LEN_BITS-1:0]  rsp_dropped_len;
   logic [CNT_W-1:0]     rsp_entry_count;
   logic [LIMIT_W-1:0]   rsp_byte_total;

   int                   error_count;
   int                   pending_count;
   int                   cycle_count = 0;
   int                   gap_pct = 0;
   int                   stall_pct = 0;
   int                   stall_left = 0;
   logic                 quiet = 1'b0;

   byte_budget_deque #(.DEPTH(DEPTH), .LEN_BITS(LEN_BITS)) u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_msg_handle     (req_msg_handle),
      .req_msg_len        (req_msg_len),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_len        (rsp_out_len),
      .rsp_dropped        (rsp_dropped),
      .rsp_dropped_handle (rsp_dropped_handle),
      .rsp_dropped_len    (rsp_dropped_len),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_byte_total     (rsp_byte_total)
   );

   bbd_deque_checker #(.DEPTH(DEPTH), .LEN_BITS(LEN_BITS)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_msg_handle     (req_msg_handle),
      .req_msg_len        (req_msg_len),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_len        (rsp_out_len),
      .rsp_dropped        (rsp_dropped),
      .rsp_dropped_handle (rsp_dropped_handle),
      .rsp_dropped_len    (rsp_dropped_len),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_byte_total     (rsp_byte_total),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!quiet && !reset && $urandom_range(99) < stall_pct) begin
         stall_left <= int'($urandom_range(11));
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_op(input logic [2:0] op, input logic [HANDLE_W-1:0] hnd,
                          input logic [LEN_BITS-1:0] len);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_msg_handle <= hnd;
      req_msg_len    <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_random(input int count, input int push_pct, input int clear_pm,
                             input int len_mode);
      logic [2:0]          op;
      logic [LEN_BITS-1:0] len;
      int                  roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(999);
         if (roll < push_pct * 10) begin
            op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end else if (roll < push_pct * 10 + clear_pm) begin
            op = OP_CLEAR;
         end else if (roll < push_pct * 10 + clear_pm + 10) begin
            op = OP_UNUSED;
         end else begin
            op = 3'($urandom_range(5, 2));
         end
         roll = $urandom_range(99);
         if (len_mode == LEN_FULL || (len_mode == LEN_TINY && roll < 5)) begin
            len = LEN_BITS'($urandom);
         end else if (len_mode == LEN_TINY) begin
            len = LEN_BITS'($urandom_range(15));
         end else if (roll < 10) begin
            len = '0;
         end else if (roll < 20) begin
            len = '1;
         end else begin
            len = LEN_BITS'($urandom_range(2000));
         end
         send_op(op, $urandom, len);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      gap_pct   = 30;
      stall_pct = 30;
      send_op(OP_POP_FRONT, 32'h0, 16'h0);
      send_op(OP_POP_BACK, 32'h0, 16'h0);
      send_op(OP_PEEK_FRONT, 32'h0, 16'h0);
      send_op(OP_PEEK_BACK, 32'h0, 16'h0);
      send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF, 16'hFFFF);
      send_op(OP_PUSH_BACK, 32'h0, 16'h0);
      send_op(OP_PUSH_BACK, 32'h1234_5678, 16'd16384);
      send_op(OP_PUSH_FRONT, 32'hA5A5_A5A5, 16'd1);
      send_op(OP_PEEK_FRONT, 32'h0, 16'h0);
      send_op(OP_PEEK_BACK, 32'h0, 16'h0);
      send_op(OP_UNUSED, 32'hDEAD_BEEF, 16'h5555);
      send_op(OP_PUSH_BACK, 32'h5A5A_5A5A, 16'd100);
      send_op(OP_POP_BACK, 32'h0, 16'h0);
      send_op(OP_POP_FRONT, 32'h0, 16'h0);
      send_op(OP_POP_FRONT, 32'h0, 16'h0);
      send_op(OP_POP_BACK, 32'h0, 16'h0);
      send_op(OP_PUSH_FRONT, 32'h0000_0001, 16'd2);
      send_op(OP_PUSH_BACK, 32'h0000_0002, 16'd3);
      send_op(OP_CLEAR, 32'h0, 16'h0);
      send_op(OP_PEEK_BACK, 32'h0, 16'h0);
      send_op(OP_PUSH_BACK, 32'h0000_0003, 16'd4);
      send_op(OP_POP_FRONT, 32'h0, 16'h0);

      write_limit('0);
      gap_pct   = 20;
      stall_pct = 20;
      run_random(250, 55, 10, LEN_MIXED);

      write_limit(LIMIT_MAX);
      gap_pct   = 10;
      stall_pct = 50;
      run_random(350, 70, 5, LEN_FULL);

      write_limit(22'd700);
      gap_pct   = 0;
      stall_pct = 0;
      run_random(300, 70, 5, LEN_TINY);

      write_limit(22'd4194239);
      gap_pct   = 50;
      stall_pct = 10;
      run_random(250, 60, 10, LEN_MIXED);

      write_limit(22'd30000);
      gap_pct   = 20;
      stall_pct = 30;
      run_random(300, 55, 10, LEN_MIXED);

      write_limit(LIMIT_W'($urandom_range(4194240)));
      run_random(250, 55, 10, LEN_FULL);

      quiet   = 1'b1;
      gap_pct = 0;
      run_random(150, 55, 10, LEN_MIXED);

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
design/bbd_pkg.sv
design/bbd_ram.sv
design/bbd_state.sv
design/byte_budget_deque.sv
test/bbd_deque_checker.sv
test/tb_byte_budget_deque.sv
